### sv/sample_window_sum_minmax_defines.svh
// assertion macros used by the sample window datapath
`ifndef SAMPLE_WINDOW_SUM_MINMAX_DEFINES_SVH
`define SAMPLE_WINDOW_SUM_MINMAX_DEFINES_SVH

// condition that must hold on every enabled clock
`define SWS_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define SWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sws_pkg.sv
// types and constants shared by the sample window sum / min-max blocks
package sws_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 8;
  localparam int WS_W     = 8;

  localparam logic [WS_W-1:0]            WS_RESET   = 8'd128;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CNT_W-1:0]           head_lag;
    logic [CNT_W-1:0]           show_max;
    logic [CNT_W-1:0]           show_min;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    running_sum;
    logic [CNT_W-1:0]           fill_count;
    logic signed [SAMPLE_W-1:0] window_max;
    logic signed [SAMPLE_W-1:0] window_min;
    logic [CNT_W-1:0]           scanned_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic push_start;
    logic push_commit;
    logic q_calc;
    logic scan_issue;
    logic query_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_query;
    logic out_free;
    logic count_zero;
    logic scan_last;
  } dp_sts_t;

endpackage

### sv/sws_ram.sv
// generic single-port-write, single-port-read ram with registered read
module sws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/sws_ctrl.sv
// control state machine: sequences push, query setup, scan and result hand-off
module sws_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sws_pkg::dp_sts_t sts,
  output sws_pkg::dp_cmd_t cmd
);
  import sws_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PUSH   = 6'b000010,
    ST_QCALC  = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (sts.in_is_query) begin
            state_nxt = ST_QCALC;
          end else begin
            cmd.push_start = 1'b1;
            state_nxt      = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.push_commit = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_QCALC: begin
        cmd.q_calc = 1'b1;
        state_nxt  = sts.count_zero ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.query_out = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/sws_dp.sv
// datapath: window registers, sample ram, query arithmetic, scan compare, output stage
`include "sample_window_sum_minmax_defines.svh"

module sws_dp #(
  parameter int DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [sws_pkg::WS_W-1:0]      cfg_wr_data,
  input  sws_pkg::in_item_t             in_data,
  input  sws_pkg::dp_cmd_t              cmd,
  output sws_pkg::dp_sts_t              sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sws_pkg::out_item_t            out_data
);
  import sws_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W+1)'(DEPTH);

  // window state
  logic [WS_W-1:0]         ws_r, ws_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [AW-1:0]           head_r, head_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  // item and scan state
  in_item_t                item_r, item_nxt;
  logic                    is_new_r, is_new_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  // output stage
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_r, out_nxt;

  // ram
  logic                    ram_rd_en;
  logic [AW-1:0]           ram_rd_addr;
  logic [SAMPLE_W-1:0]     ram_rd_data;
  logic signed [SAMPLE_W-1:0] rd_sample;

  // combinational helpers
  logic [CNT_W:0]          ws_eff9, cap9, head_inc9, hd9, lag9, start9;
  logic [CNT_W-1:0]        cap;
  logic [AW-1:0]           ph_head;
  logic [CNT_W-1:0]        ph_fill;
  logic                    ph_new;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0] sum_push;
  logic [CNT_W-1:0]        lim, lag, c1, remv, qcount, fill_m1;
  logic [AW-1:0]           qstart, idx_dec;

  sws_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push_commit),
    .wr_addr (head_r),
    .wr_data (item_r.sample),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_sample   = ram_rd_data;
  assign ram_rd_en   = cmd.push_start | cmd.scan_issue;
  assign ram_rd_addr = cmd.scan_issue ? idx_r : ph_head;

  // capacity: window size, at least 1, at most DEPTH
  always_comb begin
    ws_eff9 = (ws_r == '0) ? (CNT_W+1)'(1) : {1'b0, ws_r};
    cap9    = (ws_eff9 > DEPTH_EXT) ? DEPTH_EXT : ws_eff9;
    cap     = cap9[CNT_W-1:0];
  end

  // head and fill after a push
  always_comb begin
    head_inc9 = (CNT_W+1)'(head_r) + (CNT_W+1)'(1);
    if (fill_r < cap) begin
      ph_head = fill_r[AW-1:0];
      ph_fill = fill_r + CNT_W'(1);
      ph_new  = 1'b1;
    end else begin
      ph_head = (head_inc9 >= {1'b0, cap}) ? '0 : head_inc9[AW-1:0];
      ph_fill = fill_r;
      ph_new  = 1'b0;
    end
  end

  // entries never written since the last clear read as zero
  assign old_sample = is_new_r ? '0 : rd_sample;
  assign sum_push   = sum_r + SUM_W'(item_r.sample) - SUM_W'(old_sample);

  // query setup arithmetic
  always_comb begin
    lim    = (fill_r > item_r.show_min) ? fill_r - item_r.show_min : '0;
    lag    = (item_r.head_lag > lim) ? lim : item_r.head_lag;
    c1     = (item_r.show_max < fill_r) ? item_r.show_max : fill_r;
    remv   = fill_r - lag;
    qcount = (c1 > remv) ? remv : c1;
    hd9    = (CNT_W+1)'(head_r);
    lag9   = {1'b0, lag};
    start9 = (hd9 >= lag9) ? hd9 - lag9 : hd9 + {1'b0, fill_r} - lag9;
    qstart = start9[AW-1:0];
  end

  // backward step with wrap inside the filled part
  assign fill_m1 = fill_r - CNT_W'(1);
  assign idx_dec = (idx_r == '0) ? fill_m1[AW-1:0] : idx_r - AW'(1);

  always_comb begin
    ws_nxt        = ws_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    sum_nxt       = sum_r;
    item_nxt      = item_r;
    is_new_nxt    = is_new_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    max_nxt       = max_r;
    min_nxt       = min_r;
    rd_pend_nxt   = cmd.scan_issue;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load_item) begin
      item_nxt = in_data;
    end

    if (cmd.push_start) begin
      head_nxt   = ph_head;
      fill_nxt   = ph_fill;
      is_new_nxt = ph_new;
    end

    if (cmd.push_commit) begin
      sum_nxt                   = sum_push;
      out_valid_nxt             = 1'b1;
      out_nxt.running_sum       = sum_push;
      out_nxt.fill_count        = fill_r;
      out_nxt.window_max        = SAMPLE_MIN;
      out_nxt.window_min        = SAMPLE_MAX;
      out_nxt.scanned_count     = '0;
    end

    if (cmd.q_calc) begin
      idx_nxt = qstart;
      rem_nxt = qcount;
      cnt_nxt = qcount;
      max_nxt = SAMPLE_MIN;
      min_nxt = SAMPLE_MAX;
    end

    if (cmd.scan_issue) begin
      idx_nxt = idx_dec;
      rem_nxt = rem_r - CNT_W'(1);
    end

    if (rd_pend_r) begin
      if (rd_sample > max_r) begin
        max_nxt = rd_sample;
      end
      if (rd_sample < min_r) begin
        min_nxt = rd_sample;
      end
    end

    if (cmd.query_out) begin
      out_valid_nxt         = 1'b1;
      out_nxt.running_sum   = sum_r;
      out_nxt.fill_count    = fill_r;
      out_nxt.window_max    = max_r;
      out_nxt.window_min    = min_r;
      out_nxt.scanned_count = cnt_r;
    end

    // a new window size restarts the window
    if (cfg_wr_en) begin
      ws_nxt   = cfg_wr_data;
      fill_nxt = '0;
      head_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= WS_RESET;
      fill_r      <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ws_r        <= ws_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      sum_r       <= sum_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    is_new_r <= is_new_nxt;
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    max_r    <= max_nxt;
    min_r    <= min_nxt;
    out_r    <= out_nxt;
  end

  assign sts.in_is_query = (in_data.op == OP_QUERY);
  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.count_zero  = (qcount == '0);
  assign sts.scan_last   = (rem_r == CNT_W'(1));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SWS_ASSERT_ALW(a_fill_cap, fill_r <= cap, "fill level above capacity")
  `SWS_ASSERT_IMP(a_head_in_fill, fill_r != '0, (CNT_W+1)'(head_r) < {1'b0, fill_r},
                  "head outside filled part")
  `SWS_ASSERT_NXT(a_out_load, cmd.push_commit || cmd.query_out, out_valid_r,
                  "result not presented after load")
  `SWS_ASSERT_IMP(a_scan_rem, cmd.scan_issue, rem_r != '0, "scan read with nothing left")
  `SWS_ASSERT_IMP(a_cnt_fill, out_valid_r, out_r.scanned_count <= out_r.fill_count,
                  "scanned more samples than held")

endmodule

### sv/sample_window_sum_minmax.sv
// top level of the moving-sum window with backward min/max query
//
// in_valid / in_ready / in_data: one request, op 0 pushes in_data.sample, op 1
//   queries max and min over a backward scan set by head_lag, show_max, show_min
// out_valid / out_ready / out_data: one result per request, sum and fill level
//   after it plus max, min and scanned count (-32768 / 32767 / 0 for a push)
// cfg_wr_en / cfg_wr_data: write window_size and restart the window empty,
//   only while no request is in flight
// push: ram read in the accept cycle, write in ST_PUSH once the output register
//   is free; the result is registered together with the write
// query: ST_QCALC sets up, ST_SCAN issues one ram read per sample, ST_DRAIN
//   ends the scan, ST_FINISH loads the result; empty scans skip to ST_FINISH
// one request at a time; the next is accepted while a result waits in the
//   output register, but a result is loaded only once that register is free
// reset: window_size 128, window empty, sum zero; no ram clearing pass,
//   entries not written since the last clear read as zero
// stall: the receiver holds the result; the finished request waits until the
//   output register frees, then the block accepts again
module sample_window_sum_minmax #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [sws_pkg::WS_W-1:0] cfg_wr_data,
  // requests
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sws_pkg::in_item_t        in_data,
  // results
  output logic                     out_valid,
  input  logic                     out_ready,
  output sws_pkg::out_item_t       out_data
);
  import sws_pkg::*;

  // command and status between controller and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: push read/commit, query setup, scan, result hand-off
  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window registers, sample ram, scan compare and output register
  sws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

### verif/tb.sv
// testbench for the moving-sum sample window with backward max / min query
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam int STORE_DEPTH   = 256;
  localparam int IDLE_LIMIT    = 5000;   // cycles with no handshake on either side
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;      // a query of nothing still passes through ST_QCALC and ST_FINISH

  // handshake pacing per phase
  typedef enum int {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  logic            clk         = 1'b0;
  logic            rst_n       = 1'b0;
  logic            cfg_wr_en   = 1'b0;
  logic [WS_W-1:0] cfg_wr_data = WS_RESET;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  in_item_t        in_data     = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  out_item_t       out_data;

  sample_window_sum_minmax #(
    .DEPTH(STORE_DEPTH)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the window: store, fill level, head, sum and window size
  logic signed [SAMPLE_W-1:0] win_store [STORE_DEPTH];
  int unsigned                win_fill;
  int unsigned                win_head;
  logic [SUM_W-1:0]           win_sum;
  logic [WS_W-1:0]            win_size;

  // results predicted for accepted requests, oldest first
  out_item_t awaited_reports[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned n_push         = 0;
  int unsigned n_query        = 0;
  int unsigned n_size_writes  = 0;
  int unsigned deepest_scan   = 0;

  task automatic report_mismatch(string msg);
    $display("%t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // a window size write (and reset) empties the window
  task automatic clear_window();
    foreach (win_store[i]) win_store[i] = '0;
    win_fill = 0;
    win_head = 0;
    win_sum  = '0;
  endtask

  // advance the shadow window by one request and return its result
  function automatic out_item_t apply_request(in_item_t req);
    out_item_t   rep;
    int unsigned cap;
    int unsigned lag;
    int unsigned lim;
    int unsigned cnt;
    int unsigned idx;
    int unsigned i;
    int          hi;
    int          lo;
    hi  = SAMPLE_MIN;
    lo  = SAMPLE_MAX;
    cnt = 0;
    if (req.op == OP_PUSH) begin
      // size zero still holds one sample
      cap = (win_size == 0) ? 1 : win_size;
      if (win_fill < cap) begin
        win_head = win_fill;
        win_fill++;
      end else begin
        // full: overwrite the oldest, head wraps at the capacity
        win_head++;
        if (win_head >= cap) win_head = 0;
      end
      win_sum = SUM_W'(int'(win_sum) + int'(req.sample) - int'(win_store[win_head]));
      win_store[win_head] = req.sample;
    end else begin
      // lag may not hide more than fill - show_min samples
      lag = req.head_lag;
      lim = (win_fill > req.show_min) ? win_fill - req.show_min : 0;
      if (lag > lim) lag = lim;
      cnt = (req.show_max < win_fill) ? req.show_max : win_fill;
      if (cnt > win_fill - lag) cnt = win_fill - lag;
      if (cnt > 0) begin
        // start wraps below zero, scan runs backward through the filled part
        idx = (win_head + win_fill - lag % win_fill) % win_fill;
        for (i = 0; i < cnt; i++) begin
          if (win_store[idx] > hi) hi = win_store[idx];
          if (win_store[idx] < lo) lo = win_store[idx];
          idx = (idx == 0) ? win_fill - 1 : idx - 1;
        end
      end
      if (cnt > deepest_scan) deepest_scan = cnt;
    end
    rep.running_sum   = win_sum;
    rep.fill_count    = CNT_W'(win_fill);
    rep.window_max    = SAMPLE_W'(hi);
    rep.window_min    = SAMPLE_W'(lo);
    rep.scanned_count = CNT_W'(cnt);
    return rep;
  endfunction

  // counts: tiny, near the fill level, or any byte
  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(2))
      0: return CNT_W'($urandom_range(4));
      1: return CNT_W'($urandom_range((win_fill + 2 > 255) ? 255 : win_fill + 2));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_request(int unsigned push_pct);
    in_item_t req;
    req.op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_QUERY;
    case ($urandom_range(7))
      0: req.sample = SAMPLE_MIN;
      1: req.sample = SAMPLE_MAX;
      default: req.sample = SAMPLE_W'($urandom);
    endcase
    req.head_lag = pick_count();
    req.show_max = pick_count();
    req.show_min = pick_count();
    return req;
  endfunction

  // fields a push ignores are still random
  function automatic in_item_t make_push(logic signed [SAMPLE_W-1:0] value);
    in_item_t req;
    req.op       = OP_PUSH;
    req.sample   = value;
    req.head_lag = CNT_W'($urandom);
    req.show_max = CNT_W'($urandom);
    req.show_min = CNT_W'($urandom);
    return req;
  endfunction

  function automatic in_item_t make_query(int unsigned lag, int unsigned smax,
                                          int unsigned smin);
    in_item_t req;
    req.op       = OP_QUERY;
    req.sample   = SAMPLE_W'($urandom);
    req.head_lag = CNT_W'(lag);
    req.show_max = CNT_W'(smax);
    req.show_min = CNT_W'(smin);
    return req;
  endfunction

  task automatic set_pace(pace_t pace);
    case (pace)
      PACE_FREE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        send_idle_pct  = 62;
        recv_stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        send_idle_pct  = 0;
        recv_stall_pct = 62;
      end
      default: begin
        send_idle_pct  = 36;
        recv_stall_pct = 36;
      end
    endcase
  endtask

  // one request; valid stays high after acceptance so back-to-back requests
  // need no second assignment in the same step
  task automatic send_request(in_item_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_reports.push_back(apply_request(req));
    if (req.op == OP_PUSH) n_push++;
    else n_query++;
  endtask

  // hold off new requests until every predicted result has come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only on an idle block; the window restarts empty
  task automatic write_window_size(logic [WS_W-1:0] ws);
    drain_reports();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ws;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_size = ws;
    clear_window();
    n_size_writes++;
  endtask

  // reset window of 128: empty query, sample extremes, every clamp of the query
  task automatic test_empty_and_extremes();
    set_pace(PACE_FREE);
    send_request(make_query(0, 255, 0));      // empty window, empty scan
    send_request(make_push(SAMPLE_MAX));
    send_request(make_push(SAMPLE_MIN));
    send_request(make_push(16'sd0));
    send_request(make_push(-16'sd1));
    send_request(make_push(16'sd1234));
    send_request(make_query(0, 255, 0));      // whole window
    send_request(make_query(255, 255, 0));    // lag eats the window, nothing scanned
    send_request(make_query(1, 255, 255));    // show_min forces lag to zero
    send_request(make_query(0, 0, 0));        // show_max zero
    send_request(make_query(2, 255, 1));
    send_request(make_query(1, 2, 0));
  endtask

  // window size zero behaves as one, then size one itself
  task automatic test_capacity_one();
    write_window_size(8'd0);
    send_request(make_push(16'sd100));
    send_request(make_push(-16'sd200));       // overwrites the only entry
    send_request(make_query(0, 255, 0));
    write_window_size(8'd1);
    send_request(make_push(SAMPLE_MAX));
    send_request(make_query(0, 1, 0));
  endtask

  // small window: head wraps and the scan start wraps below zero
  task automatic test_wrap();
    write_window_size(8'd3);
    send_request(make_push(16'sd10));
    send_request(make_push(16'sd20));
    send_request(make_push(16'sd30));
    send_request(make_push(16'sd40));
    send_request(make_push(16'sd50));
    send_request(make_query(0, 3, 0));
    send_request(make_query(2, 255, 0));
    send_request(make_query(1, 255, 1));
  endtask

  // random phases over window sizes from capacity one to 255, pacing rotated
  task automatic test_random_windows();
    logic [WS_W-1:0] sizes [10];
    int unsigned     n_items;
    int unsigned     push_pct;
    int unsigned     p;
    int unsigned     k;
    sizes = '{8'd1, 8'd2, 8'd5, 8'd16, 8'd255, WS_RESET, 8'd64, 8'd0, 8'd7, 8'd0};
    sizes[9] = WS_W'($urandom_range(1, 255));
    for (p = 0; p < 10; p++) begin
      write_window_size(sizes[p]);
      set_pace(pace_t'(p % 4));
      // the largest window needs enough pushes to fill and wrap
      n_items  = (sizes[p] == 8'd255) ? 530 : 135;
      push_pct = (sizes[p] == 8'd255) ? 75 : 65;
      for (k = 0; k < n_items; k++) send_request(random_request(push_pct));
    end
  endtask

  // sender stops mid-stream until every result is back, then resumes
  task automatic test_drain_pause();
    int unsigned k;
    write_window_size(8'd9);
    set_pace(PACE_BOTH);
    for (k = 0; k < 40; k++) send_request(random_request(65));
    drain_reports();
    for (k = 0; k < 40; k++) send_request(random_request(65));
  endtask

  // receiver pacing, drawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch($sformatf("result with none pending, sum %0d",
                                  out_data.running_sum));
      end else begin
        want = awaited_reports.pop_front();
        if (out_data.running_sum !== want.running_sum)
          report_mismatch($sformatf("running_sum got %0d want %0d",
                                    out_data.running_sum, want.running_sum));
        if (out_data.fill_count !== want.fill_count)
          report_mismatch($sformatf("fill_count got %0d want %0d",
                                    out_data.fill_count, want.fill_count));
        if (out_data.window_max !== want.window_max)
          report_mismatch($sformatf("window_max got %0d want %0d",
                                    out_data.window_max, want.window_max));
        if (out_data.window_min !== want.window_min)
          report_mismatch($sformatf("window_min got %0d want %0d",
                                    out_data.window_min, want.window_min));
        if (out_data.scanned_count !== want.scanned_count)
          report_mismatch($sformatf("scanned_count got %0d want %0d",
                                    out_data.scanned_count, want.scanned_count));
      end
    end
  end

  // end the run when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%t no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  initial begin
    int unsigned waited;
    win_size = WS_RESET;
    clear_window();
    set_pace(PACE_FREE);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_capacity_one();
    test_wrap();
    test_random_windows();
    test_drain_pause();

    // let the last results come back, then let the block settle
    in_valid <= 1'b0;
    waited = 0;
    while (awaited_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_reports.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_reports.size()));

    $display("covered %0d pushes and %0d queries over %0d window size writes",
             n_push, n_query, n_size_writes);
    $display("capacities one to 255, deepest scan %0d samples, %0d mismatches",
             deepest_scan, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
